/* src/stp_pkg.sv */
`timescale 1ns / 1ps

package stp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // operation codes
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_BWD = 1'b1;

    // per-word control carried down the pipe
    typedef struct packed {
        logic op;
        logic xn;
        logic yn;
        logic zn;
        logic bad;
    } t_ctl;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* src/stp_in_if.sv */
`timescale 1ns / 1ps

interface stp_in_if #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;

    modport source (output valid, operation, x_in, y_in, z_in, input ready);
    modport sink   (input valid, operation, x_in, y_in, z_in, output ready);
endinterface

/* src/stp_out_if.sv */
`timescale 1ns / 1ps

interface stp_out_if #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
    logic                          valid_res;
    logic                          saturated;

    modport source (output valid, x_out, y_out, z_out, valid_res, saturated, input ready);
    modport sink   (input valid, x_out, y_out, z_out, valid_res, saturated, output ready);
endinterface

/* src/stereographic_projection_top.sv */
`timescale 1ns / 1ps

// Stereographic projection, signed fixed point, one result word per input word.
// Input channel i_in: operation (0 forward sphere to plane, 1 backward plane to
// sphere) and x_in, y_in, z_in; z_in is unused in backward. Output channel
// o_out: x_out, y_out, z_out, valid_res and saturated. Both use valid/ready;
// a word moves when both are high.
// Throughput: one word per cycle while the receiver keeps ready high. Stages:
// three front stages (magnitude, square, sum), one cell per root bit of the
// square root chain, one setup stage, one cell per quotient bit (COORD_WIDTH+1)
// of the three-lane divider chain, and the output register.
// Every stage holds a valid bit and takes a new word when it is empty or its
// neighbor downstream takes its word, so a stalled receiver fills the chain one
// stage at a time; bubbles are squeezed out and input keeps flowing until the
// chain is full. Nothing is dropped or repeated under stalls.
// Reset clears all valid bits; the block holds no other state and is ready as
// soon as reset has cleared them.
module stereographic_projection_top #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = stp_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stp_in_if.sink     i_in,
    stp_out_if.source  o_out
);
    localparam int W     = COORD_WIDTH;
    localparam int QB    = W + 1;
    localparam int DW    = stp_pkg::f_max(2*W, 2*FRAC_BITS + 1);
    localparam int CTLW  = $bits(stp_pkg::t_ctl);
    localparam int PW_SQ = CTLW + 5*W;
    localparam int PW_DV = 3 + CTLW + 2*W;

    // front to root chain
    logic                 sq_valid [0:W];
    logic                 sq_ready [0:W];
    logic [W+1:0]         sq_rem   [0:W];
    logic [W-1:0]         sq_root  [0:W];
    logic [2*W-1:0]       sq_rad   [0:W];
    logic [PW_SQ-1:0]     sq_pass  [0:W];
    stp_pkg::t_ctl        fr_ctl, sq_ctl;
    logic [W-1:0]         fr_xm, fr_ym, fr_zm, sq_xm, sq_ym, sq_zm;
    logic [2*W-1:0]       fr_s, sq_s;

    // divider chain
    logic                 dv_valid [0:QB];
    logic                 dv_ready [0:QB];
    logic [DW-1:0]        dv_d     [0:QB];
    logic [2:0][DW-1:0]   dv_rem   [0:QB];
    logic [2:0][QB-1:0]   dv_num   [0:QB];
    logic [2:0][QB-1:0]   dv_q     [0:QB];
    logic [PW_DV-1:0]     dv_pass  [0:QB];
    stp_pkg::t_ctl        su_ctl, pk_ctl;
    logic [2:0]           su_ovf, pk_ovf;
    logic [2*W-1:0]       su_s, pk_s;

    stp_front #(
        .COORD_WIDTH (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_op    (i_in.operation),
        .i_x     (i_in.x_in),
        .i_y     (i_in.y_in),
        .i_z     (i_in.z_in),
        .o_valid (sq_valid[0]),
        .i_ready (sq_ready[0]),
        .o_ctl   (fr_ctl),
        .o_xm    (fr_xm),
        .o_ym    (fr_ym),
        .o_zm    (fr_zm),
        .o_s     (fr_s)
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = fr_s;
    assign sq_pass[0] = {fr_ctl, fr_xm, fr_ym, fr_zm, fr_s};

    // square root, one bit per cell
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        stp_sqrt_cell #(
            .COORD_WIDTH (W),
            .PASS_WIDTH  (PW_SQ)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[k]),
            .o_ready (sq_ready[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_rad   (sq_rad[k]),
            .i_pass  (sq_pass[k]),
            .o_valid (sq_valid[k+1]),
            .i_ready (sq_ready[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_pass  (sq_pass[k+1])
        );
    end

    assign {sq_ctl, sq_xm, sq_ym, sq_zm, sq_s} = sq_pass[W];

    stp_setup #(
        .COORD_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS),
        .DW          (DW),
        .QB          (QB)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid[W]),
        .o_ready (sq_ready[W]),
        .i_ctl   (sq_ctl),
        .i_xm    (sq_xm),
        .i_ym    (sq_ym),
        .i_zm    (sq_zm),
        .i_root  (sq_root[W]),
        .i_s     (sq_s),
        .o_valid (dv_valid[0]),
        .i_ready (dv_ready[0]),
        .o_ctl   (su_ctl),
        .o_d     (dv_d[0]),
        .o_rem   (dv_rem[0]),
        .o_num   (dv_num[0]),
        .o_ovf   (su_ovf),
        .o_s     (su_s)
    );

    assign dv_q[0]    = '0;
    assign dv_pass[0] = {su_ovf, su_ctl, su_s};

    // division, one quotient bit per cell
    for (genvar k = 0; k < QB; k++) begin : g_div
        stp_div_cell #(
            .DW         (DW),
            .QB         (QB),
            .PASS_WIDTH (PW_DV)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[k]),
            .o_ready (dv_ready[k]),
            .i_d     (dv_d[k]),
            .i_rem   (dv_rem[k]),
            .i_num   (dv_num[k]),
            .i_q     (dv_q[k]),
            .i_pass  (dv_pass[k]),
            .o_valid (dv_valid[k+1]),
            .i_ready (dv_ready[k+1]),
            .o_d     (dv_d[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_num   (dv_num[k+1]),
            .o_q     (dv_q[k+1]),
            .o_pass  (dv_pass[k+1])
        );
    end

    assign {pk_ovf, pk_ctl, pk_s} = dv_pass[QB];

    stp_pack #(
        .COORD_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS),
        .QB          (QB)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid[QB]),
        .o_ready     (dv_ready[QB]),
        .i_ctl       (pk_ctl),
        .i_q         (dv_q[QB]),
        .i_ovf       (pk_ovf),
        .i_s         (pk_s),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_x         (o_out.x_out),
        .o_y         (o_out.y_out),
        .o_z         (o_out.z_out),
        .o_valid_res (o_out.valid_res),
        .o_sat       (o_out.saturated)
    );

endmodule

/* src/stp_front.sv */
`timescale 1ns / 1ps

// Magnitudes, squares and the squared length, three registered stages
module stp_front #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output stp_pkg::t_ctl                 o_ctl,
    output logic [COORD_WIDTH-1:0]        o_xm,
    output logic [COORD_WIDTH-1:0]        o_ym,
    output logic [COORD_WIDTH-1:0]        o_zm,
    output logic [2*COORD_WIDTH-1:0]      o_s
);
    localparam int W = COORD_WIDTH;

    logic                 a_ready, b_ready, c_ready;
    logic                 r_a_valid, r_b_valid, r_c_valid;
    stp_pkg::t_ctl        n_a_ctl, r_a_ctl, r_b_ctl, r_c_ctl;
    logic [W-1:0]         n_a_xm, n_a_ym, n_a_zm;
    logic [W-1:0]         r_a_xm, r_a_ym, r_a_zm;
    logic [W-1:0]         r_b_xm, r_b_ym, r_b_zm;
    logic [W-1:0]         r_c_xm, r_c_ym, r_c_zm;
    logic [2*W-1:0]       r_b_xx, r_b_yy, r_b_zz;
    logic [2*W-1:0]       n_c_s, r_c_s;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // sign and magnitude split; the most negative code maps to 2^(W-1)
    always_comb begin
        n_a_ctl.op  = i_op;
        n_a_ctl.xn  = i_x[W-1];
        n_a_ctl.yn  = i_y[W-1];
        n_a_ctl.zn  = i_z[W-1];
        n_a_ctl.bad = 1'b0;
        n_a_xm = i_x[W-1] ? W'(~i_x + W'(1)) : W'(i_x);
        n_a_ym = i_y[W-1] ? W'(~i_y + W'(1)) : W'(i_y);
        n_a_zm = i_z[W-1] ? W'(~i_z + W'(1)) : W'(i_z);
    end

    // squared length; z only counts in forward
    assign n_c_s = r_b_xx + r_b_yy + ((r_b_ctl.op == stp_pkg::OP_FWD) ? r_b_zz : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_ctl <= n_a_ctl;
            r_a_xm  <= n_a_xm;
            r_a_ym  <= n_a_ym;
            r_a_zm  <= n_a_zm;
        end
        if (b_ready && r_a_valid) begin
            r_b_ctl <= r_a_ctl;
            r_b_xm  <= r_a_xm;
            r_b_ym  <= r_a_ym;
            r_b_zm  <= r_a_zm;
            r_b_xx  <= {{W{1'b0}}, r_a_xm} * {{W{1'b0}}, r_a_xm};
            r_b_yy  <= {{W{1'b0}}, r_a_ym} * {{W{1'b0}}, r_a_ym};
            r_b_zz  <= {{W{1'b0}}, r_a_zm} * {{W{1'b0}}, r_a_zm};
        end
        if (c_ready && r_b_valid) begin
            r_c_ctl <= r_b_ctl;
            r_c_xm  <= r_b_xm;
            r_c_ym  <= r_b_ym;
            r_c_zm  <= r_b_zm;
            r_c_s   <= n_c_s;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ctl   = r_c_ctl;
    assign o_xm    = r_c_xm;
    assign o_ym    = r_c_ym;
    assign o_zm    = r_c_zm;
    assign o_s     = r_c_s;

endmodule

/* src/stp_sqrt_cell.sv */
`timescale 1ns / 1ps

// One root bit of a digit-by-digit integer square root
module stp_sqrt_cell #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF,
    parameter int PASS_WIDTH  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [COORD_WIDTH+1:0]     i_rem,
    input  logic [COORD_WIDTH-1:0]     i_root,
    input  logic [2*COORD_WIDTH-1:0]   i_rad,
    input  logic [PASS_WIDTH-1:0]      i_pass,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [COORD_WIDTH+1:0]     o_rem,
    output logic [COORD_WIDTH-1:0]     o_root,
    output logic [2*COORD_WIDTH-1:0]   o_rad,
    output logic [PASS_WIDTH-1:0]      o_pass
);
    localparam int W = COORD_WIDTH;

    logic             r_valid;
    logic [W+3:0]     t, trial;
    logic             ge;
    logic [W+1:0]     n_rem, r_rem;
    logic [W-1:0]     r_root;
    logic [2*W-1:0]   r_rad;
    logic [PASS_WIDTH-1:0] r_pass;

    assign o_ready = !r_valid || i_ready;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        t     = {i_rem, i_rad[2*W-1:2*W-2]};
        trial = (W+4)'({i_root, 2'b01});
        ge    = (t >= trial);
        n_rem = ge ? (W+2)'(t - trial) : (W+2)'(t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_root <= {i_root[W-2:0], ge};
            r_rad  <= {i_rad[2*W-3:0], 2'b00};
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_pass  = r_pass;

endmodule

/* src/stp_setup.sv */
`timescale 1ns / 1ps

// Forms divisor, numerators and overflow checks for the divider chain
module stp_setup #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = stp_pkg::FRAC_BITS_DEF,
    parameter int DW          = 2 * COORD_WIDTH,
    parameter int QB          = COORD_WIDTH + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  stp_pkg::t_ctl              i_ctl,
    input  logic [COORD_WIDTH-1:0]     i_xm,
    input  logic [COORD_WIDTH-1:0]     i_ym,
    input  logic [COORD_WIDTH-1:0]     i_zm,
    input  logic [COORD_WIDTH-1:0]     i_root,
    input  logic [2*COORD_WIDTH-1:0]   i_s,
    output logic                       o_valid,
    input  logic                       i_ready,
    output stp_pkg::t_ctl              o_ctl,
    output logic [DW-1:0]              o_d,
    output logic [2:0][DW-1:0]         o_rem,
    output logic [2:0][QB-1:0]         o_num,
    output logic [2:0]                 o_ovf,
    output logic [2*COORD_WIDTH-1:0]   o_s
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = stp_pkg::f_max(W + 2*F, 3*F + 2);
    localparam int CW = stp_pkg::f_max(NW, DW);

    logic                 r_valid;
    logic [W:0]           h2;
    logic                 fwd, bad;
    stp_pkg::t_ctl        n_ctl, r_ctl;
    logic [DW-1:0]        n_d, r_d;
    logic [2:0][NW-1:0]   num, hi;
    logic [2:0][DW-1:0]   n_rem, r_rem;
    logic [2:0][QB-1:0]   r_num;
    logic [2:0]           n_ovf, r_ovf;
    logic [2*W-1:0]       r_s;

    assign o_ready = !r_valid || i_ready;

    // 2h = r - z; not positive means no projection
    always_comb begin
        fwd   = (i_ctl.op == stp_pkg::OP_FWD);
        h2    = i_ctl.zn ? ({1'b0, i_root} + {1'b0, i_zm}) : ({1'b0, i_root} - {1'b0, i_zm});
        bad   = fwd && !i_ctl.zn && (i_root <= i_zm);
        n_ctl = i_ctl;
        n_ctl.bad = bad;
        if (fwd) begin
            n_d    = bad ? DW'(1) : DW'(h2);
            num[0] = NW'(i_xm) << (F + 1);
            num[1] = NW'(i_ym) << (F + 1);
            num[2] = '0;
        end else begin
            n_d    = DW'(i_s >> 2) + (DW'(1) << (2*F));
            num[0] = NW'(i_xm) << (2*F);
            num[1] = NW'(i_ym) << (2*F);
            num[2] = NW'(1) << (3*F + 1);
        end
        for (int i = 0; i < 3; i++) begin
            hi[i]    = num[i] >> QB;
            n_ovf[i] = (CW'(hi[i]) >= CW'(n_d));
            n_rem[i] = DW'(hi[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_d   <= n_d;
            r_rem <= n_rem;
            r_ovf <= n_ovf;
            r_s   <= i_s;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= num[i][QB-1:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_ovf   = r_ovf;
    assign o_s     = r_s;

endmodule

/* src/stp_div_cell.sv */
`timescale 1ns / 1ps

// One quotient bit of restoring division, three lanes on a shared divisor
module stp_div_cell #(
    parameter int DW         = 64,
    parameter int QB         = 33,
    parameter int PASS_WIDTH = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DW-1:0]         i_d,
    input  logic [2:0][DW-1:0]    i_rem,
    input  logic [2:0][QB-1:0]    i_num,
    input  logic [2:0][QB-1:0]    i_q,
    input  logic [PASS_WIDTH-1:0] i_pass,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DW-1:0]         o_d,
    output logic [2:0][DW-1:0]    o_rem,
    output logic [2:0][QB-1:0]    o_num,
    output logic [2:0][QB-1:0]    o_q,
    output logic [PASS_WIDTH-1:0] o_pass
);
    logic                  r_valid;
    logic [2:0][DW:0]      t;
    logic [2:0]            ge;
    logic [2:0][DW-1:0]    n_rem, r_rem;
    logic [2:0][QB-1:0]    r_num, r_q;
    logic [DW-1:0]         r_d;
    logic [PASS_WIDTH-1:0] r_pass;

    assign o_ready = !r_valid || i_ready;

    // shift in next numerator bit, subtract divisor when it fits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i]     = {i_rem[i], i_num[i][QB-1]};
            ge[i]    = (t[i] >= {1'b0, i_d});
            n_rem[i] = ge[i] ? DW'(t[i] - {1'b0, i_d}) : DW'(t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d    <= i_d;
            r_rem  <= n_rem;
            r_pass <= i_pass;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {i_num[i][QB-2:0], 1'b0};
                r_q[i]   <= {i_q[i][QB-2:0], ge[i]};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_q     = r_q;
    assign o_pass  = r_pass;

endmodule

/* src/stp_pack.sv */
`timescale 1ns / 1ps

// Sign, clamp and output register
module stp_pack #(
    parameter int COORD_WIDTH = stp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = stp_pkg::FRAC_BITS_DEF,
    parameter int QB          = COORD_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  stp_pkg::t_ctl                 i_ctl,
    input  logic [2:0][QB-1:0]            i_q,
    input  logic [2:0]                    i_ovf,
    input  logic [2*COORD_WIDTH-1:0]      i_s,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic signed [COORD_WIDTH-1:0] o_z,
    output logic                          o_valid_res,
    output logic                          o_sat
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = 2*W + 2;

    logic          r_valid;
    logic [W:0]    px, py, pz;
    logic [MW-1:0] one, tz;
    logic [W-1:0]  n_x, n_y, n_z, r_x, r_y, r_z;
    logic          n_vr, n_sat, r_vr, r_sat;

    // returns {clamped, value}
    function automatic logic [W:0] f_pack(input logic neg, input logic [MW-1:0] mag,
                                          input logic ovf);
        logic [MW-1:0] lim;
        logic [W-1:0]  v;
        logic          sat;
        lim = neg ? (MW'(1) << (W-1)) : ((MW'(1) << (W-1)) - MW'(1));
        sat = ovf || (mag > lim);
        v   = sat ? lim[W-1:0] : mag[W-1:0];
        return {sat, neg ? W'(~v + W'(1)) : v};
    endfunction

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        one = MW'(1) << F;
        tz  = MW'(i_q[2]);
        px  = f_pack(i_ctl.xn, MW'(i_q[0]), i_ovf[0]);
        py  = f_pack(i_ctl.yn, MW'(i_q[1]), i_ovf[1]);
        if (i_ctl.op == stp_pkg::OP_FWD) begin
            pz = f_pack(1'b0, MW'(i_s >> F), 1'b0);
        end else if (!i_ovf[2] && (tz <= one)) begin
            pz = f_pack(1'b0, one - tz, 1'b0);
        end else begin
            pz = f_pack(1'b1, tz - one, i_ovf[2]);
        end
        if (i_ctl.bad) begin
            // no projection: saturated sentinels
            n_x   = {1'b0, {(W-1){1'b1}}};
            n_y   = {1'b0, {(W-1){1'b1}}};
            n_z   = {1'b1, {(W-1){1'b0}}};
            n_vr  = 1'b0;
            n_sat = 1'b1;
        end else begin
            n_x   = px[W-1:0];
            n_y   = py[W-1:0];
            n_z   = pz[W-1:0];
            n_vr  = 1'b1;
            n_sat = px[W] || py[W] || pz[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_vr  <= n_vr;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_z         = r_z;
    assign o_valid_res = r_vr;
    assign o_sat       = r_sat;

    a_fail_is_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_vr |-> r_sat)
        else $error("failed projection without saturated flag");
    a_fail_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_vr |-> (r_z == {1'b1, {(W-1){1'b0}}}) && (r_x == r_y))
        else $error("failed projection sentinels wrong");
    a_unsat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid && !i_ctl.bad && !i_ovf[0] && !(|i_q[0][QB-1:W]) && !n_sat
        |=> r_valid && r_vr)
        else $error("unclamped word lost or marked invalid");
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_valid)
        else $error("output valid after reset");

endmodule

/* verif/stereographic_projection_top_test.sv */
`timescale 1ns / 1ps

module stereographic_projection_top_test;

    localparam int CW        = stp_pkg::COORD_WIDTH_DEF;
    localparam int FB        = stp_pkg::FRAC_BITS_DEF;
    localparam int NUM_RAND  = 1330;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          vres;
        logic          sat;
    } t_proj;

    typedef struct {
        logic          op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        bit            known;
        t_proj         res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    stp_in_if  #(.COORD_WIDTH(CW)) in_if ();
    stp_out_if #(.COORD_WIDTH(CW)) out_if ();

    stereographic_projection_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_proj proj_due[$];
    int    fail_cnt  = 0;
    int    words_out = 0;

    // floor square root of a wide unsigned value
    function automatic logic [63:0] root_floor(input logic [127:0] s);
        logic [127:0] res;
        logic [127:0] c;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (128'd1 << b);
            if (c * c <= s) res = c;
        end
        return res[63:0];
    endfunction

    // clamp a sign/magnitude value into the signed coordinate range
    function automatic logic [CW-1:0] clamp_coord(input bit neg, input logic [127:0] mag,
                                                  inout bit sat);
        logic [127:0] lim;
        logic [CW-1:0] v;
        lim = neg ? (128'd1 << (CW-1)) : ((128'd1 << (CW-1)) - 1);
        if (mag > lim) begin
            sat = 1;
            v   = lim[CW-1:0];
        end else begin
            v = mag[CW-1:0];
        end
        return neg ? (~v + 1'b1) : v;
    endfunction

    function automatic t_proj project(input logic op, input logic [CW-1:0] x,
                                      input logic [CW-1:0] y, input logic [CW-1:0] z);
        t_proj        r;
        bit           sat;
        bit           xn, yn, zn;
        logic [127:0] xm, ym, zm, s, h2, q, d, t, one;
        logic [63:0]  rt;
        sat = 0;
        xn  = x[CW-1];
        yn  = y[CW-1];
        zn  = z[CW-1];
        xm  = xn ? 128'(CW'(~x + 1'b1)) : 128'(x);
        ym  = yn ? 128'(CW'(~y + 1'b1)) : 128'(y);
        zm  = zn ? 128'(CW'(~z + 1'b1)) : 128'(z);
        r.vres = 1;
        if (op == stp_pkg::OP_FWD) begin
            s  = xm * xm + ym * ym + zm * zm;
            rt = root_floor(s);
            if (zn) h2 = rt + zm;
            else if (rt > zm) h2 = rt - zm;
            else begin
                // point at or beyond the pole: sentinels
                r.x    = {1'b0, {(CW-1){1'b1}}};
                r.y    = {1'b0, {(CW-1){1'b1}}};
                r.z    = {1'b1, {(CW-1){1'b0}}};
                r.vres = 0;
                r.sat  = 1;
                return r;
            end
            r.x = clamp_coord(xn, (xm << (FB + 1)) / h2, sat);
            r.y = clamp_coord(yn, (ym << (FB + 1)) / h2, sat);
            r.z = clamp_coord(0, s >> FB, sat);
        end else begin
            q   = (xm * xm + ym * ym) >> 2;
            d   = q + (128'd1 << (2 * FB));
            t   = (128'd1 << (3 * FB + 1)) / d;
            one = 128'd1 << FB;
            r.x = clamp_coord(xn, (xm << (2 * FB)) / d, sat);
            r.y = clamp_coord(yn, (ym << (2 * FB)) / d, sat);
            if (t <= one) r.z = clamp_coord(0, one - t, sat);
            else r.z = clamp_coord(1, t - one, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic op, input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z, input int gap, input bit known,
                             input t_proj res);
        if (gap > 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1;
        in_if.operation <= op;
        in_if.x_in      <= x;
        in_if.y_in      <= y;
        in_if.z_in      <= z;
        do @(posedge i_clk); while (!in_if.ready);
        proj_due.push_back(known ? res : project(op, x, y, z));
    endtask

    function automatic logic [CW-1:0] rand_coord();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) return CW'($urandom_range(0, 1 << 19)) - CW'(1 << 18);
        if (kind < 9) return CW'($urandom);
        unique case ($urandom_range(0, 4))
            0: return '0;
            1: return CW'(1);
            2: return '1;
            3: return {1'b0, {(CW-1){1'b1}}};
            default: return {1'b1, {(CW-1){1'b0}}};
        endcase
    endfunction

    // directed table, then random words
    initial begin
        t_row rows[$];
        t_proj none;
        int gap;
        none = '0;
        in_if.valid     <= 0;
        in_if.operation <= stp_pkg::OP_FWD;
        in_if.x_in      <= '0;
        in_if.y_in      <= '0;
        in_if.z_in      <= '0;
        i_rst_n         <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // origin and north pole fail forward; origin maps to south pole backward
        rows.push_back('{stp_pkg::OP_FWD, 32'h0, 32'h0, 32'h0, 1,
                         '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b1}});
        rows.push_back('{stp_pkg::OP_FWD, 32'h0, 32'h0, 32'h00010000, 1,
                         '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b1}});
        rows.push_back('{stp_pkg::OP_FWD, 32'h0, 32'h0, 32'h7fffffff, 1,
                         '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b1}});
        rows.push_back('{stp_pkg::OP_BWD, 32'h0, 32'h0, 32'h0, 1,
                         '{32'h0, 32'h0, 32'hffff0000, 1'b1, 1'b0}});
        rows.push_back('{stp_pkg::OP_FWD, 32'h00010000, 32'h0, 32'h0, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h0, 32'hffff0000, 32'h0, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h0, 32'h0, 32'hffff0000, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h00008000, 32'h00008000, 32'h0000b505, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h80000000, 32'h80000000, 32'h80000000, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h00000001, 32'h0, 32'h80000000, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'h80000000, 32'h7fffffff, 32'h00000001, 0, none});
        rows.push_back('{stp_pkg::OP_FWD, 32'hffffffff, 32'h00000001, 32'h0, 0, none});
        rows.push_back('{stp_pkg::OP_BWD, 32'h00020000, 32'h0, 32'h7fffffff, 0, none});
        rows.push_back('{stp_pkg::OP_BWD, 32'h7fffffff, 32'h7fffffff, 32'h0, 0, none});
        rows.push_back('{stp_pkg::OP_BWD, 32'h80000000, 32'h80000000, 32'h80000000, 0, none});
        rows.push_back('{stp_pkg::OP_BWD, 32'h00000001, 32'hffffffff, 32'h0, 0, none});
        rows.push_back('{stp_pkg::OP_BWD, 32'hfffe0000, 32'h00010000, 32'h12345678, 0, none});

        foreach (rows[i])
            send_word(rows[i].op, rows[i].x, rows[i].y, rows[i].z,
                      $urandom_range(0, 2), rows[i].known, rows[i].res);

        for (int n = 0; n < NUM_RAND; n++) begin
            // drain fully once mid-run
            if (n == NUM_RAND / 2) begin
                in_if.valid <= 0;
                while (proj_due.size() != 0) @(posedge i_clk);
            end
            gap = ((n / 100) % 4 == 1) ? 0 : $urandom_range(0, 8);
            send_word(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      gap, 0, none);
        end
        in_if.valid <= 0;

        while (proj_due.size() != 0) @(posedge i_clk);
        repeat (2 * CW + 20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver stalls, one long hold-off to back the pipe up
    initial begin
        int stall;
        bit held;
        held = 0;
        out_if.ready <= 0;
        @(posedge i_rst_n);
        forever begin
            stall = (((words_out / 150) % 4) == 2) ? 0 : $urandom_range(0, 8);
            if (!held && words_out >= 300) begin
                held  = 1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                out_if.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_proj got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            words_out <= words_out + 1;
            got = '{out_if.x_out, out_if.y_out, out_if.z_out, out_if.valid_res,
                    out_if.saturated};
            if (proj_due.size() == 0) begin
                $error("result word with nothing pending");
                fail_cnt++;
            end else begin
                want = proj_due.pop_front();
                if (got.x !== want.x) begin
                    $error("x_out expected %h got %h", want.x, got.x);
                    fail_cnt++;
                end
                if (got.y !== want.y) begin
                    $error("y_out expected %h got %h", want.y, got.y);
                    fail_cnt++;
                end
                if (got.z !== want.z) begin
                    $error("z_out expected %h got %h", want.z, got.z);
                    fail_cnt++;
                end
                if (got.vres !== want.vres) begin
                    $error("valid_res expected %b got %b", want.vres, got.vres);
                    fail_cnt++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated expected %b got %b", want.sat, got.sat);
                    fail_cnt++;
                end
            end
        end
    end

endmodule
